// ----- rtl/ctf_pkg.sv -----
// Package for the complementary tilt filter: shared types, register indexes,
// controller command/status structs and the CORDIC arctangent table.
// No dependencies.
package ctf_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_MAG_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WT   = 2'd3;

    localparam logic [16:0] MAG_LOW_RST    = 17'd8192;
    localparam logic [16:0] MAG_HIGH_RST   = 17'd32768;
    localparam logic [15:0] GYRO_SCALE_RST = 16'd10;
    localparam logic [16:0] BLEND_WT_RST   = 17'd64225;

    // CORDIC word width: 16-bit magnitude scaled by 2^24, plus growth and sign.
    localparam int unsigned CW = 44;
    // Angle accumulator, units of 2^-32 degree, room for sign and overshoot.
    localparam int unsigned ZW = 41;
    localparam int unsigned ATAN_LEN = 24;
    localparam int unsigned ITER_W = 5;

    // Input transfer: one IMU sample.
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
    } t_sample;

    // Output transfer: updated angles and the blend flag.
    typedef struct packed {
        logic signed [31:0] pitch_deg;
        logic signed [31:0] roll_deg;
        logic               accel_corrected;
    } t_angles;

    typedef struct packed {
        logic load;       // capture sample, integrate gyro
        logic cordic_init; // start a CORDIC pass
        logic cordic_step; // one vectoring iteration
        logic sel_roll;   // 0: pitch pass, 1: roll pass
        logic mult_lo;    // blend product, first half
        logic mult_hi;    // blend product, second half and write back
    } t_cmd;

    typedef struct packed {
        logic corr;
        logic iter_last;
    } t_stat;

    function automatic logic [ZW-1:0] atan_q32(input logic [ITER_W-1:0] i);
        logic [ZW-1:0] v;
        case (i)
            5'd0:  v = 41'd193273528320;
            5'd1:  v = 41'd114096026024;
            5'd2:  v = 41'd60285206653;
            5'd3:  v = 41'd30601712202;
            5'd4:  v = 41'd15360239180;
            5'd5:  v = 41'd7687607525;
            5'd6:  v = 41'd3844741810;
            5'd7:  v = 41'd1922488225;
            5'd8:  v = 41'd961258780;
            5'd9:  v = 41'd480631223;
            5'd10: v = 41'd240315840;
            5'd11: v = 41'd120157949;
            5'd12: v = 41'd60078978;
            5'd13: v = 41'd30039489;
            5'd14: v = 41'd15019745;
            5'd15: v = 41'd7509873;
            5'd16: v = 41'd3754937;
            5'd17: v = 41'd1877468;
            5'd18: v = 41'd938734;
            5'd19: v = 41'd469367;
            5'd20: v = 41'd234684;
            5'd21: v = 41'd117342;
            5'd22: v = 41'd58671;
            5'd23: v = 41'd29335;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/ctf_stream_if.sv -----
// Valid/ready channel carrying one payload type.
// Depends on nothing; the payload type is a parameter.
interface ctf_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ctf_ctrl.sv -----
// Sequencer for the complementary tilt filter.
// Depends on ctf_pkg (command and status structs).
module ctf_ctrl #(
    parameter int unsigned CORDIC_ITERATIONS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  ctf_pkg::t_stat  i_stat,
    output ctf_pkg::t_cmd   o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_ITER = 3'd2;
    localparam logic [2:0] S_MLO  = 3'd3;
    localparam logic [2:0] S_MHI  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_roll, n_roll;

    always_comb begin
        n_state = r_state;
        n_roll  = r_roll;
        o_cmd   = '0;
        o_cmd.sel_roll = r_roll;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_INIT;
                    n_roll  = 1'b0;
                end
            end
            S_INIT: begin
                if (!i_stat.corr) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.cordic_init = 1'b1;
                    n_state = (CORDIC_ITERATIONS == 0) ? S_MLO : S_ITER;
                end
            end
            S_ITER: begin
                o_cmd.cordic_step = 1'b1;
                if (i_stat.iter_last) n_state = S_MLO;
            end
            S_MLO: begin
                o_cmd.mult_lo = 1'b1;
                n_state = S_MHI;
            end
            S_MHI: begin
                o_cmd.mult_hi = 1'b1;
                if (r_roll) begin
                    n_state = S_OUT;
                end else begin
                    n_roll  = 1'b1;
                    n_state = S_INIT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_roll  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_roll  <= n_roll;
        end
    end

`ifndef SYNTHESIS
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready and valid together");
    a_step_after_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mult_hi |-> $past(o_cmd.mult_lo)) else $error("blend out of order");
    a_load_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !o_in_ready) else $error("accepted twice");
`endif
endmodule

// ----- rtl/ctf_datapath.sv -----
// Datapath for the complementary tilt filter: gyro integration, shared
// iterative CORDIC, blend multiply in a low and a high half. Depends on ctf_pkg.
module ctf_datapath #(
    parameter int unsigned ANGLE_FRAC_BITS   = 16,
    parameter int unsigned CORDIC_ITERATIONS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ctf_pkg::t_cmd        i_cmd,
    output ctf_pkg::t_stat       o_stat,
    input  logic signed [15:0]   i_ax,
    input  logic signed [15:0]   i_ay,
    input  logic signed [15:0]   i_az,
    input  logic signed [15:0]   i_gx,
    input  logic signed [15:0]   i_gy,
    input  logic [16:0]          i_mag_low,
    input  logic [16:0]          i_mag_high,
    input  logic [15:0]          i_gyro_scale,
    input  logic [16:0]          i_blend_wt,
    output logic signed [31:0]   o_pitch,
    output logic signed [31:0]   o_roll,
    output logic                 o_corr
);
    localparam int unsigned CW = ctf_pkg::CW;
    localparam int unsigned ZW = ctf_pkg::ZW;
    localparam int unsigned IW = ctf_pkg::ITER_W;
    localparam int unsigned NIT = (CORDIC_ITERATIONS < ctf_pkg::ATAN_LEN) ?
                                  CORDIC_ITERATIONS : ctf_pkg::ATAN_LEN;
    localparam int unsigned SH = 32 - ANGLE_FRAC_BITS;
    localparam int unsigned AW = 8 + ANGLE_FRAC_BITS + 2; // signed atan2 result
    localparam logic signed [AW-1:0] DEG180 = AW'(180) <<< ANGLE_FRAC_BITS;

    logic signed [31:0] r_pitch, r_roll;
    logic signed [15:0] r_ax, r_ay, r_az;
    logic               r_corr;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [IW-1:0]        r_it;
    logic                 r_xneg, r_yneg;
    logic signed [49:0]   r_plo;

    function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
        if (v > 51'sd2147483647)       return 32'sh7fffffff;
        else if (v < -51'sd2147483648) return 32'sh80000000;
        else                           return v[31:0];
    endfunction

    function automatic logic [16:0] absv(input logic signed [15:0] v);
        return v[15] ? 17'(-$signed({v[15], v})) : {1'b0, v};
    endfunction

    // Gyro integration products.
    logic signed [32:0] gx_p, gy_p;
    assign gx_p = i_gx * $signed({1'b0, i_gyro_scale});
    assign gy_p = i_gy * $signed({1'b0, i_gyro_scale});

    logic [18:0] mag;
    assign mag = 19'(absv(i_ax)) + 19'(absv(i_ay)) + 19'(absv(i_az));

    // CORDIC operand selection.
    logic signed [15:0] cy_src;
    assign cy_src = i_cmd.sel_roll ? r_ax : r_ay;

    logic signed [CW-1:0] dx, dy;
    assign dx = r_y >>> r_it;
    assign dy = r_x >>> r_it;

    // Final angle from accumulator.
    logic signed [ZW-1:0] zc;
    logic [ZW-1:0]        zr;
    logic signed [AW-1:0] aq, a1, acc;
    always_comb begin
        if (r_z < 0) zc = '0;
        else if (r_z > (ZW'(90) <<< 32)) zc = ZW'(90) <<< 32;
        else zc = r_z;
        zr = (ZW'(zc) + (ZW'(1) << (SH - 1))) >> SH;
        aq = AW'(zr);
        a1 = r_xneg ? DEG180 - aq : aq;
        acc = r_yneg ? -a1 : a1;
    end

    // Blend: angle*w + acc*(65536-w), split into the mult_lo and mult_hi steps.
    logic [16:0] w;
    logic signed [31:0] ang_sel;
    logic signed [49:0] p_hi;
    logic signed [50:0] sum;
    assign w = (i_blend_wt > 17'd65536) ? 17'd65536 : i_blend_wt;
    assign ang_sel = i_cmd.sel_roll ? r_roll : r_pitch;
    assign p_hi = 50'(acc) * $signed(50'(18'd65536 - 18'(w)));
    assign sum = 51'(r_plo) + 51'(p_hi) + 51'sd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= '0;
            r_roll  <= '0;
            r_corr  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_pitch <= sat32(51'(r_pitch) + 51'(gx_p));
                r_roll  <= sat32(51'(r_roll) + 51'(gy_p));
                r_corr  <= (mag > 19'(i_mag_low)) && (mag < 19'(i_mag_high));
            end
            if (i_cmd.mult_hi) begin
                if (i_cmd.sel_roll) r_roll  <= sat32(sum >>> 16);
                else                r_pitch <= sat32(sum >>> 16);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax <= i_ax;
            r_ay <= i_ay;
            r_az <= i_az;
        end
        if (i_cmd.cordic_init) begin
            r_x    <= CW'({absv(r_az), 24'd0});
            r_y    <= CW'({absv(cy_src), 24'd0});
            r_z    <= '0;
            r_it   <= '0;
            r_xneg <= r_az[15];
            r_yneg <= cy_src[15];
        end else if (i_cmd.cordic_step) begin
            if (r_y > 0) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + $signed(ctf_pkg::atan_q32(r_it));
            end else if (r_y < 0) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - $signed(ctf_pkg::atan_q32(r_it));
            end
            r_it <= r_it + 1'b1;
        end
        if (i_cmd.mult_lo) r_plo <= 50'(ang_sel) * $signed({33'd0, w});
    end

    assign o_stat.corr      = r_corr;
    assign o_stat.iter_last = (r_it == IW'(NIT - 1));
    assign o_pitch = r_pitch;
    assign o_roll  = r_roll;
    assign o_corr  = r_corr;

`ifndef SYNTHESIS
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cordic_step |-> r_it < IW'(NIT)) else $error("CORDIC overran");
    a_corr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_cmd.load) |-> $stable(r_corr)) else $error("corr changed");
    a_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mult_lo |-> (r_x >= 0)) else $error("CORDIC x negative");
`endif
endmodule

// ----- rtl/complementary_tilt_filter.sv -----
// Top level of the complementary tilt filter; instantiates ctf_ctrl and
// ctf_datapath. Depends on ctf_pkg and ctf_stream_if.
//
// One IMU sample enters per transfer on the input channel and produces one
// transfer on the output channel with updated pitch and roll (signed degrees,
// ANGLE_FRAC_BITS fraction bits) and a flag telling whether the accelerometer
// blend was applied. The block handles one sample at a time. A sample without
// correction goes from the set-up state straight to the output state; a
// corrected sample runs the shared iterative CORDIC twice (pitch, then roll)
// at one iteration per cycle, each pass with a set-up step and a blend
// multiply in a low and a high step, before its result is offered. The next
// sample is accepted in the cycle after the result transfer. Configuration
// writes take effect immediately and are meant for idle periods; writes to
// unknown indexes are ignored.
module complementary_tilt_filter #(
    parameter int unsigned ANGLE_FRAC_BITS   = 16,
    parameter int unsigned CORDIC_ITERATIONS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ctf_stream_if.sink                        s_in,
    ctf_stream_if.source                      m_out,
    input  logic                              i_cfg_we,
    input  logic [ctf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ctf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    // Input payload: accel_x, accel_y, accel_z, gyro_x, gyro_y.
    // Output payload: pitch_deg, roll_deg, accel_corrected.

    logic [16:0] r_mag_low, r_mag_high, r_blend_wt;
    logic [15:0] r_gyro_scale;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_low    <= ctf_pkg::MAG_LOW_RST;
            r_mag_high   <= ctf_pkg::MAG_HIGH_RST;
            r_gyro_scale <= ctf_pkg::GYRO_SCALE_RST;
            r_blend_wt   <= ctf_pkg::BLEND_WT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ctf_pkg::REG_MAG_LOW:    r_mag_low    <= i_cfg_data;
                ctf_pkg::REG_MAG_HIGH:   r_mag_high   <= i_cfg_data;
                ctf_pkg::REG_GYRO_SCALE: r_gyro_scale <= i_cfg_data[15:0];
                ctf_pkg::REG_BLEND_WT:   r_blend_wt   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ctf_pkg::t_cmd  cmd;
    ctf_pkg::t_stat stat;

    ctf_ctrl #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_in.valid),
        .o_in_ready  (s_in.ready),
        .o_out_valid (m_out.valid),
        .i_out_ready (m_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ctf_datapath #(
        .ANGLE_FRAC_BITS   (ANGLE_FRAC_BITS),
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_ax         (s_in.data.accel_x),
        .i_ay         (s_in.data.accel_y),
        .i_az         (s_in.data.accel_z),
        .i_gx         (s_in.data.gyro_x),
        .i_gy         (s_in.data.gyro_y),
        .i_mag_low    (r_mag_low),
        .i_mag_high   (r_mag_high),
        .i_gyro_scale (r_gyro_scale),
        .i_blend_wt   (r_blend_wt),
        .o_pitch      (m_out.data.pitch_deg),
        .o_roll       (m_out.data.roll_deg),
        .o_corr       (m_out.data.accel_corrected)
    );

`ifndef SYNTHESIS
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.data))
        else $error("output dropped while stalled");
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.valid && s_in.ready |=> !s_in.ready) else $error("second sample taken");
    a_no_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> !s_in.ready) else $error("ready while result pending");
`endif
endmodule

// ----- verif/complementary_tilt_filter_tb.sv -----
// Self-checking testbench for complementary_tilt_filter: drives IMU samples
// and register writes, predicts pitch/roll and the blend flag in a scoreboard.
// Depends on ctf_pkg, ctf_stream_if and the complementary_tilt_filter RTL.
module complementary_tilt_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS   = 16;
    localparam int ITERATIONS  = 16;
    // Idle cycles that cover the slowest sample, corrected, plus margin.
    localparam int SETTLE      = 60;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT = 5000;

    // Tilt-angle scoreboard: its own copy of the filter state and registers,
    // plus the queue of angle results still owed by the block.
    class tilt_scoreboard;
        logic signed [31:0] pitch, roll;
        logic [16:0] mag_low, mag_high, weight;
        logic [15:0] step_scale;
        ctf_pkg::t_angles pending[$];
        int          errors;
        longint      atan_tab[24];

        function new();
            atan_tab = '{64'sd193273528320, 64'sd114096026024, 64'sd60285206653,
                         64'sd30601712202, 64'sd15360239180, 64'sd7687607525,
                         64'sd3844741810, 64'sd1922488225, 64'sd961258780,
                         64'sd480631223, 64'sd240315840, 64'sd120157949,
                         64'sd60078978, 64'sd30039489, 64'sd15019745,
                         64'sd7509873, 64'sd3754937, 64'sd1877468,
                         64'sd938734, 64'sd469367, 64'sd234684,
                         64'sd117342, 64'sd58671, 64'sd29335};
            pitch = 0;
            roll = 0;
            mag_low = ctf_pkg::MAG_LOW_RST;
            mag_high = ctf_pkg::MAG_HIGH_RST;
            step_scale = ctf_pkg::GYRO_SCALE_RST;
            weight = ctf_pkg::BLEND_WT_RST;
            errors = 0;
        endfunction

        function void write_reg(logic [ctf_pkg::CFG_IDX_W-1:0] idx,
                                logic [ctf_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                ctf_pkg::REG_MAG_LOW:    mag_low = val;
                ctf_pkg::REG_MAG_HIGH:   mag_high = val;
                ctf_pkg::REG_GYRO_SCALE: step_scale = val[15:0];
                ctf_pkg::REG_BLEND_WT:   weight = val;
                default: ;
            endcase
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Vectoring CORDIC on the folded operands, then unfolded to +-180.
        function longint atan2_deg(longint y, longint x);
            longint cx, cy, z, dx, dy, a;
            cx = (x < 0 ? -x : x) << 24;
            cy = (y < 0 ? -y : y) << 24;
            z = 0;
            for (int i = 0; i < ITERATIONS; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy > 0) begin
                    cx += dx; cy -= dy; z += atan_tab[i];
                end else if (cy < 0) begin
                    cx -= dx; cy += dy; z -= atan_tab[i];
                end
            end
            if (z < 0) z = 0;
            if (z > (64'sd90 << 32)) z = 64'sd90 << 32;
            a = (z + (64'sd1 << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
            if (x < 0) a = (64'sd180 << FRAC_BITS) - a;
            if (y < 0) a = -a;
            return a;
        endfunction

        function longint blend(longint angle, longint acc);
            longint w;
            w = (weight > 17'd65536) ? 64'sd65536 : longint'(weight);
            return sat32((angle * w + acc * (65536 - w) + 32768) >>> 16);
        endfunction

        function void note_sample(ctf_pkg::t_sample s);
            longint ax, ay, az, mag;
            ctf_pkg::t_angles r;
            ax = s.accel_x;
            ay = s.accel_y;
            az = s.accel_z;
            pitch = 32'(sat32(longint'(pitch) + longint'(s.gyro_x) * longint'(step_scale)));
            roll  = 32'(sat32(longint'(roll) + longint'(s.gyro_y) * longint'(step_scale)));
            mag = (ax < 0 ? -ax : ax) + (ay < 0 ? -ay : ay) + (az < 0 ? -az : az);
            r.accel_corrected = (mag > longint'(mag_low)) && (mag < longint'(mag_high));
            if (r.accel_corrected) begin
                pitch = 32'(blend(pitch, atan2_deg(ay, az)));
                roll  = 32'(blend(roll, atan2_deg(ax, az)));
            end
            r.pitch_deg = pitch;
            r.roll_deg = roll;
            pending.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(ctf_pkg::t_angles got);
            ctf_pkg::t_angles want;
            if (pending.size() == 0) begin
                report("unexpected result", got.pitch_deg, 32'd0);
                return;
            end
            want = pending.pop_front();
            if (got.pitch_deg !== want.pitch_deg) report("pitch_deg", got.pitch_deg, want.pitch_deg);
            if (got.roll_deg !== want.roll_deg) report("roll_deg", got.roll_deg, want.roll_deg);
            if (got.accel_corrected !== want.accel_corrected)
                report("accel_corrected", 32'(got.accel_corrected),
                       32'(want.accel_corrected));
        endtask
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [ctf_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [ctf_pkg::CFG_DATA_W-1:0] i_cfg_data;

    ctf_stream_if #(.T(ctf_pkg::t_sample)) in_ch ();
    ctf_stream_if #(.T(ctf_pkg::t_angles)) out_ch ();

    complementary_tilt_filter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_in       (in_ch),
        .m_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    tilt_scoreboard tilt_sb = new();

    // Percent chances of a sender gap and of a receiver stall per cycle.
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    // Cycles left in a long receiver hold-off, used to back up the input.
    int rx_hold_cycles = 0;
    int quiet_cycles = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Receiver: checks each result transfer, then picks next cycle's ready.
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) begin
            tilt_sb.check_result(out_ch.data);
        end
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (rx_hold_cycles > 0) begin
            rx_hold_cycles <= rx_hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL complementary_tilt_filter");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offers one sample, after a random gap, and waits for its transfer.
    // Valid is only lowered when at least one idle cycle follows.
    task send_sample(ctf_pkg::t_sample s);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= s;
        do @(posedge i_clk); while (!in_ch.ready);
        tilt_sb.note_sample(s);
    endtask

    // One register write, followed by a cycle with the enable low.
    task write_reg(logic [ctf_pkg::CFG_IDX_W-1:0] idx, logic [ctf_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tilt_sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Drops valid, waits for every owed result, then lets the block settle.
    task drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tilt_sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task set_regs(logic [16:0] lo, logic [16:0] hi, logic [15:0] scale, logic [16:0] wt);
        write_reg(ctf_pkg::REG_MAG_LOW, lo);
        write_reg(ctf_pkg::REG_MAG_HIGH, hi);
        write_reg(ctf_pkg::REG_GYRO_SCALE, {1'b0, scale});
        write_reg(ctf_pkg::REG_BLEND_WT, wt);
    endtask

    function automatic ctf_pkg::t_sample mk(int ax, int ay, int az, int gx, int gy);
        ctf_pkg::t_sample s;
        s.accel_x = 16'(ax);
        s.accel_y = 16'(ay);
        s.accel_z = 16'(az);
        s.gyro_x = 16'(gx);
        s.gyro_y = 16'(gy);
        return s;
    endfunction

    // Most samples are near 1 g so the blend path runs; the rest are raw noise.
    function automatic ctf_pkg::t_sample random_sample();
        ctf_pkg::t_sample s;
        s = ctf_pkg::t_sample'(80'({$urandom, $urandom, $urandom}));
        if ($urandom_range(99) < 65) begin
            s.accel_x = 16'(int'($urandom_range(0, 12000)) - 6000);
            s.accel_y = 16'(int'($urandom_range(0, 12000)) - 6000);
            s.accel_z = 16'(int'($urandom_range(0, 24000)) - 12000);
            if ($urandom_range(1) != 0) begin
                s.gyro_x = 16'(int'($urandom_range(0, 400)) - 200);
                s.gyro_y = 16'(int'($urandom_range(0, 400)) - 200);
            end
        end
        return s;
    endfunction

    task random_phase(int n, int idle_pct, int stall_pct);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (n) send_sample(random_sample());
        drain();
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed samples at the reset register values.
        send_sample(mk(0, 0, 0, 0, 0));                 // zero vector, no blend
        send_sample(mk(0, 0, 16384, 100, -100));        // level, blended
        send_sample(mk(0, 0, -16384, 0, 0));            // x negative on the axis
        send_sample(mk(16384, 0, -100, 0, 0));
        send_sample(mk(-16384, -200, 100, 0, 0));
        send_sample(mk(0, 16384, 0, 0, 0));             // plus ninety degrees
        send_sample(mk(0, -16384, 0, 0, 0));            // minus ninety degrees
        send_sample(mk(4096, 4096, 0, 0, 0));           // exactly at the lower bound
        send_sample(mk(16384, 16383, 1, 0, 0));         // exactly at the upper bound
        send_sample(mk(-32768, -32768, -32768, -32768, -32768));
        send_sample(mk(32767, 32767, 32767, 32767, 32767));
        send_sample(mk(-5000, 7000, -9000, 1, -1));
        drain();

        // Extreme gains: blend always on, weight at one, fast saturation.
        set_regs(17'd0, 17'd98304, 16'hFFFF, 17'd65536);
        repeat (4) send_sample(mk(100, 100, 100, 32767, -32768));
        repeat (4) send_sample(mk(-100, 100, 100, -32768, 32767));
        drain();

        // Weight above one and weight zero, i.e. pure accelerometer angle.
        set_regs(17'd1000, 17'd60000, 16'd100, 17'h1FFFF);
        send_sample(mk(3000, -4000, 8000, 500, -500));
        send_sample(mk(-3000, 4000, -8000, 500, -500));
        drain();
        write_reg(ctf_pkg::REG_BLEND_WT, 17'd0);
        send_sample(mk(3000, -4000, 8000, 500, -500));
        send_sample(mk(0, 0, -9000, 0, 0));
        drain();

        set_regs(ctf_pkg::MAG_LOW_RST, ctf_pkg::MAG_HIGH_RST, ctf_pkg::GYRO_SCALE_RST,
                 ctf_pkg::BLEND_WT_RST);
        random_phase(80, 0, 0);

        set_regs(17'd0, 17'd98304, 16'hFFFF, 17'd65536);
        random_phase(60, 81, 0);

        // Window closed: low bound above high bound, gyro scale zero.
        set_regs(17'd98304, 17'd0, 16'd0, 17'd0);
        random_phase(50, 0, 81);

        set_regs(17'd1000, 17'd60000, 16'd100, 17'd98304);
        random_phase(80, 7, 7);

        // Long receiver hold-off while samples keep coming.
        set_regs(17'd2000, 17'd40000, 16'd1, 17'd32768);
        rx_hold_cycles = 300;
        random_phase(100, 0, 0);

        if (tilt_sb.errors == 0 && tilt_sb.pending.size() == 0) begin
            $display("PASS complementary_tilt_filter");
        end else begin
            $display("FAIL complementary_tilt_filter");
        end
        $finish;
    end
endmodule

// ----- complementary_tilt_filter.f -----
rtl/ctf_pkg.sv
rtl/ctf_stream_if.sv
rtl/ctf_ctrl.sv
rtl/ctf_datapath.sv
rtl/complementary_tilt_filter.sv
verif/complementary_tilt_filter_tb.sv
